// File: rtl/humidity_sensor_compensation_top_assert.svh
// Assertion macros used by the checker file.
`ifndef HUMIDITY_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`define HUMIDITY_SENSOR_COMPENSATION_TOP_ASSERT_SVH

// Clocked assertion, held off while reset is high.
`define HSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define HSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsc_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_ONE      = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_TWO      = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_THREE    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUM_ONE_THREE = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUM_TWO       = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUM_FOUR      = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUM_FIVE      = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUM_SIX       = 4'd7;

  // Clamp codes carried on tuser
  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_ZERO = 2'd1;
  localparam logic [1:0] CLAMP_MAX  = 2'd2;

  // Arithmetic constants
  localparam logic [31:0] FINE_OFFSET = 32'd76800;
  localparam logic [31:0] HUM_MAX_RAW = 32'd419430400;
  localparam logic [31:0] A_ROUND     = 32'd16384;
  localparam logic [31:0] C_OFFSET    = 32'd32768;
  localparam logic [31:0] B_OFFSET    = 32'd2097152;
  localparam logic [31:0] B_ROUND     = 32'd8192;
  localparam logic [16:0] Q_MAX       = 17'd102400;

  // Pipeline shape
  localparam int unsigned FINE_STAGES = 3;
  localparam int unsigned HUM_STAGES  = 8;
  localparam int unsigned OUT_SLOTS   = 2;
  localparam int unsigned PIPE_DEPTH  = FINE_STAGES + HUM_STAGES + OUT_SLOTS;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] h13;
    logic [15:0] h2;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } hsc_coef_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] v;
    logic [15:0] raw_h;
  } hsc_fine_t;

  typedef struct packed {
    logic        valid;
    logic [16:0] q;
    logic [1:0]  flag;
  } hsc_result_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] x);
    return {{20{x[11]}}, x};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

endpackage

`default_nettype wire

// File: rtl/hsc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module hsc_cfg_regs (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             wr_en,
  input  wire [hsc_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  wire [15:0]                      wr_data,
  output hsc_pkg::hsc_coef_t              coef
);
  import hsc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TEMP_ONE:      coef.t1  <= wr_data;
        CFG_TEMP_TWO:      coef.t2  <= wr_data;
        CFG_TEMP_THREE:    coef.t3  <= wr_data;
        CFG_HUM_ONE_THREE: coef.h13 <= wr_data;
        CFG_HUM_TWO:       coef.h2  <= wr_data;
        CFG_HUM_FOUR:      coef.h4  <= wr_data[11:0];
        CFG_HUM_FIVE:      coef.h5  <= wr_data[11:0];
        CFG_HUM_SIX:       coef.h6  <= wr_data[7:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsc_fine_temp.sv
`timescale 1ns / 1ps
`default_nettype none

module hsc_fine_temp (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      en,
  input  wire                      in_valid,
  input  wire [7:0]                temp_msb,
  input  wire [7:0]                temp_lsb,
  input  wire [7:0]                temp_xlsb,
  input  wire [7:0]                hum_msb,
  input  wire [7:0]                hum_lsb,
  input  wire hsc_pkg::hsc_coef_t  coef,
  output hsc_pkg::hsc_fine_t       fine_out
);
  import hsc_pkg::*;

  logic [19:0] raw_t;
  logic [31:0] x_term;
  logic [31:0] d_term;

  logic [FINE_STAGES-1:0] vld;
  logic [31:0] m1_1, md_1;
  logic [15:0] rh_1, rh_2, rh_3;
  logic [31:0] p1_2, m2_2;
  logic [31:0] v_3;

  assign raw_t  = {temp_msb, temp_lsb, temp_xlsb[7:4]};
  assign x_term = {15'd0, raw_t[19:3]} - {15'd0, coef.t1, 1'b0};
  assign d_term = {16'd0, raw_t[19:4]} - {16'd0, coef.t1};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FINE_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_1 <= x_term * sx16(coef.t2);
      md_1 <= d_term * d_term;
      rh_1 <= {hum_msb, hum_lsb};

      p1_2 <= asr32(m1_1, 5'd11);
      m2_2 <= asr32(md_1, 5'd12) * sx16(coef.t3);
      rh_2 <= rh_1;

      v_3  <= p1_2 + asr32(m2_2, 5'd14) - FINE_OFFSET;
      rh_3 <= rh_2;
    end
  end

  assign fine_out = '{valid: vld[FINE_STAGES-1], v: v_3, raw_h: rh_3};

endmodule

`default_nettype wire

// File: rtl/hsc_hum_comp.sv
`timescale 1ns / 1ps
`default_nettype none

module hsc_hum_comp (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      en,
  input  wire hsc_pkg::hsc_fine_t  fine_in,
  input  wire hsc_pkg::hsc_coef_t  coef,
  output hsc_pkg::hsc_result_t     res
);
  import hsc_pkg::*;

  logic [HUM_STAGES-1:0] vld;
  logic [31:0] m5_1, m6_1, m3_1, base_1;
  logic [31:0] a_2, b_2, c_2;
  logic [31:0] a_3, m7_3;
  logic [31:0] a_4, m8_4;
  logic [31:0] m9_5;
  logic [31:0] m9_6, m10_6;
  logic [31:0] m9_7, m11_7;
  logic [16:0] q_8;
  logic [1:0]  flag_8;

  logic [31:0] s_5;
  logic [31:0] v_fin;
  logic [16:0] q_next;
  logic [1:0]  flag_next;

  assign s_5   = asr32(m9_5, 5'd15);
  assign v_fin = m9_7 - asr32(m11_7, 5'd4);

  always_comb begin
    if (v_fin[31]) begin
      q_next    = '0;
      flag_next = CLAMP_ZERO;
    end else if (v_fin > HUM_MAX_RAW) begin
      q_next    = Q_MAX;
      flag_next = CLAMP_MAX;
    end else begin
      q_next    = v_fin[28:12];
      flag_next = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[HUM_STAGES-2:0], fine_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_1   <= sx12(coef.h5) * fine_in.v;
      m6_1   <= fine_in.v * sx8(coef.h6);
      m3_1   <= fine_in.v * {24'd0, coef.h13[7:0]};
      base_1 <= {2'd0, fine_in.raw_h, 14'd0} - {coef.h4, 20'd0} + A_ROUND;

      a_2 <= asr32(base_1 - m5_1, 5'd15);
      b_2 <= asr32(m6_1, 5'd10);
      c_2 <= asr32(m3_1, 5'd11) + C_OFFSET;

      a_3  <= a_2;
      m7_3 <= b_2 * c_2;

      a_4  <= a_3;
      m8_4 <= (asr32(m7_3, 5'd10) + B_OFFSET) * sx16(coef.h2);

      m9_5 <= a_4 * asr32(m8_4 + B_ROUND, 5'd14);

      m9_6  <= m9_5;
      m10_6 <= s_5 * s_5;

      m9_7  <= m9_6;
      m11_7 <= asr32(m10_6, 5'd7) * {24'd0, coef.h13[15:8]};

      q_8    <= q_next;
      flag_8 <= flag_next;
    end
  end

  assign res = '{valid: vld[HUM_STAGES-1], q: q_8, flag: flag_8};

endmodule

`default_nettype wire

// File: rtl/hsc_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module hsc_out_skid (
  input  wire                                clk,
  input  wire                                rst,
  input  wire hsc_pkg::hsc_result_t          res,
  output logic                               pipe_en,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [hsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic [1:0]                         m_tuser
);
  import hsc_pkg::*;

  logic        o_valid;
  logic [16:0] o_q;
  logic [1:0]  o_flag;
  logic        k_valid;
  logic [16:0] k_q;
  logic [1:0]  k_flag;

  // Hold the pipeline only while the spare slot is occupied
  assign pipe_en = !k_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (m_tready || !o_valid) begin
      if (k_valid) begin
        o_valid <= 1'b1;
        k_valid <= 1'b0;
      end else begin
        o_valid <= res.valid;
      end
    end else if (!k_valid && res.valid) begin
      k_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !o_valid) begin
      if (k_valid) begin
        o_q    <= k_q;
        o_flag <= k_flag;
      end else begin
        o_q    <= res.q;
        o_flag <= res.flag;
      end
    end else if (!k_valid) begin
      k_q    <= res.q;
      k_flag <= res.flag;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {{(OUT_TDATA_W - 17){1'b0}}, o_q};
  assign m_tuser  = o_flag;

endmodule

`default_nettype wire

// File: rtl/humidity_sensor_compensation_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Humidity compensation for a combined temperature/humidity sensor. Each
// transaction on the slave stream carries one raw reading; the block forms
// the fine temperature term from the three temperature coefficients and
// then runs the 32-bit integer humidity compensation (int32 wrap, arithmetic
// shifts) from the six humidity coefficients. The master stream returns one
// transaction per reading: relative humidity in percent as unsigned Q.10
// (0..102400) on tdata and the clamp code on tuser (0 none, 1 clamped to
// zero, 2 clamped to maximum). A reading is accepted every clock cycle while
// tready is high; the result passes through the eleven stages of the
// multiplier chain (three for fine temperature, eight for humidity) and
// then the output register, where the first stage loads at the accepting
// edge. A two-slot output buffer lets the block keep taking readings
// while a result waits; if the sink stalls long enough to fill it, tready
// drops and the whole chain holds in place. Write coefficients through the
// cfg channel only while no reading is in flight; it is always ready and
// ignores indexes beyond the eight registers.

module humidity_sensor_compensation_top (
  input  wire                                clk,
  input  wire                                rst,
  // slave stream, tdata fields from bit 0: temp_msb[7:0], temp_lsb[7:0],
  // temp_xlsb[7:0], hum_msb[7:0], hum_lsb[7:0]
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire [hsc_pkg::IN_TDATA_W-1:0]      s_tdata,
  // master stream, tdata fields from bit 0: humidity_q10[16:0], zero pad
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [hsc_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // master tuser fields from bit 0: clamp_flag[1:0]
  output logic [1:0]                         m_tuser,
  // configuration write channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [hsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [15:0]                         cfg_data
);
  import hsc_pkg::*;

  hsc_coef_t   coef;
  hsc_fine_t   fine;
  hsc_result_t res;
  logic        pipe_en;

  // Accept a register write in any cycle
  assign cfg_ready = 1'b1;

  hsc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef)
  );

  // Advance every stage together; a transaction lands in stage one only
  // when the chain moves
  assign s_tready = pipe_en;

  hsc_fine_temp u_fine (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (s_tvalid),
    .temp_msb  (s_tdata[7:0]),
    .temp_lsb  (s_tdata[15:8]),
    .temp_xlsb (s_tdata[23:16]),
    .hum_msb   (s_tdata[31:24]),
    .hum_lsb   (s_tdata[39:32]),
    .coef      (coef),
    .fine_out  (fine)
  );

  hsc_hum_comp u_hum (
    .clk     (clk),
    .rst     (rst),
    .en      (pipe_en),
    .fine_in (fine),
    .coef    (coef),
    .res     (res)
  );

  // Decouple the sink: output register plus one spare slot
  hsc_out_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .pipe_en  (pipe_en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/hsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "humidity_sensor_compensation_top_assert.svh"

module hsc_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              s_tvalid,
  input wire                              s_tready,
  input wire                              m_tvalid,
  input wire                              m_tready,
  input wire [hsc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input wire [1:0]                        m_tuser
);
  import hsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] inflight;
  logic             s_take;
  logic             m_take;
  logic             m_wait;
  logic             count_ok;

  assign s_take   = s_tvalid && s_tready;
  assign m_take   = m_tvalid && m_tready;
  assign m_wait   = m_tvalid && !m_tready;
  assign count_ok = (inflight != '0) && (inflight <= CNT_W'(PIPE_DEPTH));

  // Track readings accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (s_take && !m_take) begin
      inflight <= inflight + 1'b1;
    end else if (m_take && !s_take) begin
      inflight <= inflight - 1'b1;
    end
  end

  `HSC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid after reset")

  `HSC_ASSERT(a_no_orphan, m_tvalid |-> count_ok, "result without a reading in flight")

  `HSC_ASSERT(a_stall_cause, !s_tready |-> $past(m_wait), "input held without output stall")

  `HSC_ASSERT(a_out_hold, m_wait |=> m_tvalid && $stable({m_tuser, m_tdata}), "stalled result changed")

endmodule

bind humidity_sensor_compensation_top hsc_checker u_chk (.*);

`default_nettype wire
